>>> sv/smlp_pkg.sv
// Package for the sparse perceptron core: sizes, op codes and shared arithmetic.
// Used by the core, the MAC and the testbenches; depends on nothing.
package smlp_pkg;

	localparam int NumInputs = 64;
	localparam int NumHidden = 64;
	localparam int NumOutputs = 16;
	localparam int MaxHiddenWeights = 4096;
	localparam int OutWeights = NumHidden * NumOutputs;
	localparam int NumBiases = NumHidden + NumOutputs;
	localparam int ResultCap = 16;
	localparam int EmitCount = (NumOutputs < ResultCap) ? NumOutputs : ResultCap;

	localparam int InAw = $clog2(NumInputs);
	localparam int HidAw = $clog2(NumHidden);
	localparam int HwAw = $clog2(MaxHiddenWeights);
	localparam int OwAw = $clog2(OutWeights);
	localparam int BiasAw = $clog2(NumBiases);
	localparam int OutCw = (EmitCount > 1) ? $clog2(EmitCount) : 1;

	typedef enum logic [2:0] {
		OP_HWEIGHT = 3'd0,
		OP_FANIN   = 3'd1,
		OP_OWEIGHT = 3'd2,
		OP_BIAS    = 3'd3,
		OP_INPUT   = 3'd4,
		OP_RUN     = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [11:0]        addr;
		logic signed [31:0] value;
		logic [5:0]         src_index;
		logic [6:0]         fan_in;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         out_index;
		logic signed [31:0] out_value;
		logic               last;
	} out_item_t;

	// Saturating add of a 48-bit product term to a 32-bit sum.
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
			input logic signed [47:0] term);
		logic signed [49:0] s;
		s = 50'(acc) + 50'(term);
		if (s > 50'sd2147483647) return 32'sh7fffffff;
		else if (s < -50'sd2147483648) return 32'sh80000000;
		else return s[31:0];
	endfunction

endpackage

>>> sv/smlp_if.sv
// Valid/ready channel interface carrying one payload struct.
// Depends on smlp_pkg for nothing; the payload type is a parameter.
interface smlp_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/smlp_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
// Stand-alone; no dependencies.
module smlp_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> sv/smlp_mac.sv
// Pipelined multiply-accumulate: register product, then saturating add.
// Depends on smlp_pkg for sat_add.
module smlp_mac (
	input  logic               clk,
	input  logic               en,
	input  logic               clr,
	input  logic signed [31:0] clr_val,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  logic               a_valid,
	output logic signed [31:0] acc_q
);
	logic signed [63:0] prod_s1;
	logic               pv_s1;

	// Product stage; the arithmetic shift in the accumulate stage floors toward minus infinity.
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		pv_s1 <= en & a_valid;
	end

	// Accumulate stage.
	always_ff @(posedge clk) begin
		if (clr) acc_q <= clr_val;
		else if (pv_s1) acc_q <= smlp_pkg::sat_add(acc_q, 48'(prod_s1 >>> 16));
	end
endmodule

>>> sv/sparse_mlp_one_hidden_relu_core.sv
// Sparse one-hidden-layer perceptron core, ReLU hidden layer, linear outputs.
// Load items are accepted only while the core is idle. A run walks the hidden layer
// weight by weight, then each output over all hidden values, and can be slowed by
// receiver stalls. The input stays blocked until the last output transfer.
// Reset clears control state only; memory contents are undefined until written.
// Depends on smlp_pkg, smlp_if, smlp_ram and smlp_mac.
module sparse_mlp_one_hidden_relu_core (
	input logic clk,
	input logic arst_n,
	smlp_if.sink   in_ch,
	smlp_if.source out_ch
);
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_HSTRT = 7'b0000010,
		ST_HWALK = 7'b0000100,
		ST_HDONE = 7'b0001000,
		ST_OSTRT = 7'b0010000,
		ST_OWALK = 7'b0100000,
		ST_OEMIT = 7'b1000000
	} st_t;

	st_t state_q;
	smlp_pkg::in_item_t it;
	assign it = in_ch.data;

	logic [smlp_pkg::HidAw:0]  h_q;
	logic [16:0]               j_q, n_q, base_q;
	logic [smlp_pkg::HidAw:0]  k_q;
	logic [smlp_pkg::OutCw:0]  o_q;
	logic [2:0]                wait_q;
	logic                      out_v_q;
	smlp_pkg::out_item_t       out_q;

	logic ld;
	assign ld = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_v_q;

	// Memory ports.
	logic hw_we, fi_we, ow_we, bi_we, in_we, hs_we;
	logic [smlp_pkg::HwAw-1:0] hw_ra;
	logic [37:0] hw_rd;
	logic [6:0] fi_rd;
	logic [smlp_pkg::HidAw-1:0] fi_ra, hs_wa, hs_ra;
	logic [smlp_pkg::OwAw-1:0] ow_ra;
	logic [31:0] ow_rd, bi_rd, in_rd, hs_rd, hs_wd;
	logic [smlp_pkg::BiasAw-1:0] bi_ra;
	logic [smlp_pkg::InAw-1:0] in_ra;

	assign hw_we = ld && it.op == smlp_pkg::OP_HWEIGHT && 32'(it.addr) < smlp_pkg::MaxHiddenWeights;
	assign fi_we = ld && it.op == smlp_pkg::OP_FANIN && 32'(it.addr) < smlp_pkg::NumHidden;
	assign ow_we = ld && it.op == smlp_pkg::OP_OWEIGHT && 32'(it.addr) < smlp_pkg::OutWeights;
	assign bi_we = ld && it.op == smlp_pkg::OP_BIAS && 32'(it.addr) < smlp_pkg::NumBiases;
	assign in_we = ld && it.op == smlp_pkg::OP_INPUT && 32'(it.addr) < smlp_pkg::NumInputs;

	smlp_ram #(.Width(38), .Depth(smlp_pkg::MaxHiddenWeights)) u_hw (.clk, .we(hw_we),
		.waddr(it.addr[smlp_pkg::HwAw-1:0]), .wdata({it.src_index, it.value}),
		.raddr(hw_ra), .rdata(hw_rd));
	smlp_ram #(.Width(7), .Depth(smlp_pkg::NumHidden)) u_fi (.clk, .we(fi_we),
		.waddr(it.addr[smlp_pkg::HidAw-1:0]), .wdata(it.fan_in), .raddr(fi_ra), .rdata(fi_rd));
	smlp_ram #(.Width(32), .Depth(smlp_pkg::OutWeights)) u_ow (.clk, .we(ow_we),
		.waddr(it.addr[smlp_pkg::OwAw-1:0]), .wdata(it.value), .raddr(ow_ra), .rdata(ow_rd));
	smlp_ram #(.Width(32), .Depth(smlp_pkg::NumBiases)) u_bi (.clk, .we(bi_we),
		.waddr(it.addr[smlp_pkg::BiasAw-1:0]), .wdata(it.value), .raddr(bi_ra), .rdata(bi_rd));
	smlp_ram #(.Width(32), .Depth(smlp_pkg::NumInputs)) u_in (.clk, .we(in_we),
		.waddr(it.addr[smlp_pkg::InAw-1:0]), .wdata(it.value), .raddr(in_ra), .rdata(in_rd));
	smlp_ram #(.Width(32), .Depth(smlp_pkg::NumHidden)) u_hs (.clk, .we(hs_we),
		.waddr(hs_wa), .wdata(hs_wd), .raddr(hs_ra), .rdata(hs_rd));

	// Walk pipeline: weight read (s1), input read (s2), MAC.
	logic               rd_v_s1, rd_v_s2, ok_s1, ok_s2;
	logic signed [31:0] w_s2;
	logic               walk_rd;
	logic [16:0]        wa;
	assign wa = base_q + j_q;
	assign walk_rd = (state_q == ST_HWALK) && j_q < n_q;

	assign hw_ra = wa[smlp_pkg::HwAw-1:0];
	assign in_ra = hw_rd[32 +: smlp_pkg::InAw];
	assign fi_ra = h_q[smlp_pkg::HidAw-1:0];
	assign ow_ra = smlp_pkg::OwAw'(32'(o_q) * smlp_pkg::NumHidden + 32'(k_q));
	assign hs_ra = k_q[smlp_pkg::HidAw-1:0];
	assign bi_ra = (state_q == ST_OSTRT || state_q == ST_OWALK) ?
		smlp_pkg::BiasAw'(smlp_pkg::NumHidden + 32'(o_q)) : smlp_pkg::BiasAw'(h_q);

	always_ff @(posedge clk) begin
		rd_v_s1 <= walk_rd;
		ok_s1 <= 32'(wa) < smlp_pkg::MaxHiddenWeights;
		rd_v_s2 <= rd_v_s1;
		ok_s2 <= ok_s1 && 32'(hw_rd[37:32]) < smlp_pkg::NumInputs;
		w_s2 <= hw_rd[31:0];
	end

	// Output walk read stage.
	logic ord_v_s1;
	always_ff @(posedge clk) ord_v_s1 <= (state_q == ST_OWALK) && 32'(k_q) < smlp_pkg::NumHidden;

	logic hid_mode;
	assign hid_mode = (state_q == ST_HWALK || state_q == ST_HDONE);
	logic signed [31:0] ma, mb, acc;
	logic mv, clr;
	assign ma = hid_mode ? w_s2 : ow_rd;
	assign mb = hid_mode ? in_rd : hs_rd;
	assign mv = hid_mode ? (rd_v_s2 && ok_s2) : ord_v_s1;
	assign clr = (state_q == ST_HSTRT || state_q == ST_OSTRT) && wait_q == 3'd1;

	smlp_mac u_mac (.clk, .en(1'b1), .clr, .clr_val(bi_rd), .a(ma), .b(mb),
		.a_valid(mv), .acc_q(acc));

	assign hs_we = (state_q == ST_HDONE) && wait_q == 3'd0;
	assign hs_wa = h_q[smlp_pkg::HidAw-1:0];
	assign hs_wd = (acc > 0) ? acc : 32'sd0;

	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;

	// Run sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			h_q <= '0; j_q <= '0; n_q <= '0; base_q <= '0; k_q <= '0; o_q <= '0;
			wait_q <= '0; out_v_q <= 1'b0;
		end else begin
			if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (ld && it.op == smlp_pkg::OP_RUN) begin
						state_q <= ST_HSTRT; h_q <= '0; base_q <= '0; wait_q <= 3'd2;
					end
				end
				ST_HSTRT: begin
					// Fan-in and bias reads land; seed the accumulator.
					wait_q <= wait_q - 3'd1;
					if (wait_q == 3'd1) begin
						n_q <= 17'(fi_rd); j_q <= '0; state_q <= ST_HWALK;
					end
				end
				ST_HWALK: begin
					if (j_q < n_q) j_q <= j_q + 17'd1;
					else begin
						state_q <= ST_HDONE; wait_q <= 3'd3;
					end
				end
				ST_HDONE: begin
					// Drain the pipeline, then store ReLU result.
					if (wait_q != 3'd0) wait_q <= wait_q - 3'd1;
					else begin
						base_q <= base_q + n_q;
						if (32'(h_q) + 1 == smlp_pkg::NumHidden) begin
							state_q <= ST_OSTRT; o_q <= '0; wait_q <= 3'd2;
						end else begin
							h_q <= h_q + 1'b1; state_q <= ST_HSTRT; wait_q <= 3'd2;
						end
					end
				end
				ST_OSTRT: begin
					wait_q <= wait_q - 3'd1;
					k_q <= '0;
					if (wait_q == 3'd1) state_q <= ST_OWALK;
				end
				ST_OWALK: begin
					if (32'(k_q) < smlp_pkg::NumHidden) k_q <= k_q + 1'b1;
					else begin
						state_q <= ST_OEMIT; wait_q <= 3'd3;
					end
				end
				ST_OEMIT: begin
					if (wait_q != 3'd0) wait_q <= wait_q - 3'd1;
					else if (!out_v_q) begin
						out_v_q <= 1'b1;
						out_q.out_index <= 4'(o_q);
						out_q.out_value <= acc;
						out_q.last <= 32'(o_q) + 1 == smlp_pkg::EmitCount;
						if (32'(o_q) + 1 == smlp_pkg::EmitCount) state_q <= ST_IDLE;
						else begin
							o_q <= o_q + 1'b1; state_q <= ST_OSTRT; wait_q <= 3'd2;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> tb/sparse_mlp_one_hidden_relu_core_chk.sv
// Checker for the sparse perceptron core: watches both channels, predicts each run's outputs.
// Depends on smlp_pkg and smlp_if.
`timescale 1ns / 1ps
module sparse_mlp_one_hidden_relu_core_chk (
	input logic clk,
	input logic arst_n,
	smlp_if in_ch,
	smlp_if out_ch,
	output int fail_count,
	output int pending
);
	import smlp_pkg::*;

	logic signed [31:0] act_mem [NumInputs];
	logic signed [31:0] hid_val [NumHidden];
	logic signed [31:0] hw_mem [MaxHiddenWeights];
	logic [5:0]         hidx_mem [MaxHiddenWeights];
	logic [6:0]         fan_mem [NumHidden];
	logic signed [31:0] ow_mem [OutWeights];
	logic signed [31:0] b_mem [NumBiases];
	out_item_t          expected_outputs [$];

	// Q16.16 product, truncated toward minus infinity.
	function automatic logic signed [47:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return 48'(p >>> 16);
	endfunction

	function automatic logic signed [31:0] fx_acc(logic signed [31:0] acc,
			logic signed [47:0] t);
		logic signed [49:0] s;
		s = 50'(acc) + 50'(t);
		if (s > 50'sd2147483647) return 32'sh7fffffff;
		if (s < -50'sd2147483648) return 32'sh80000000;
		return s[31:0];
	endfunction

	// Computes one inference and queues its outputs.
	task automatic predict_outputs();
		int base;
		int wa;
		logic signed [31:0] acc;
		out_item_t r;
		base = 0;
		for (int h = 0; h < NumHidden; h++) begin
			acc = b_mem[h];
			for (int j = 0; j < fan_mem[h]; j++) begin
				wa = base + j;
				if (wa < MaxHiddenWeights && hidx_mem[wa] < NumInputs)
					acc = fx_acc(acc, fx_mul(hw_mem[wa], act_mem[hidx_mem[wa]]));
			end
			hid_val[h] = (acc > 0) ? acc : 0;
			base += fan_mem[h];
		end
		for (int o = 0; o < EmitCount; o++) begin
			acc = b_mem[NumHidden + o];
			for (int h = 0; h < NumHidden; h++)
				acc = fx_acc(acc, fx_mul(ow_mem[o * NumHidden + h], hid_val[h]));
			r.out_index = 4'(o);
			r.out_value = acc;
			r.last = (o == EmitCount - 1);
			expected_outputs.push_back(r);
		end
	endtask

	assign pending = expected_outputs.size();

	initial fail_count = 0;

	// Input transfers update the memories or launch a prediction.
	always @(posedge clk) begin
		in_item_t it;
		it = in_ch.data;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			case (it.op)
				OP_HWEIGHT: if (it.addr < MaxHiddenWeights) begin
					hw_mem[it.addr] = it.value;
					hidx_mem[it.addr] = it.src_index;
				end
				OP_FANIN: if (it.addr < NumHidden) fan_mem[it.addr] = it.fan_in;
				OP_OWEIGHT: if (it.addr < OutWeights) ow_mem[it.addr] = it.value;
				OP_BIAS: if (it.addr < NumBiases) b_mem[it.addr] = it.value;
				OP_INPUT: if (it.addr < NumInputs) act_mem[it.addr] = it.value;
				OP_RUN: predict_outputs();
				default: ;
			endcase
		end
	end

	// Output transfers are compared against the oldest expectation.
	always @(posedge clk) begin
		out_item_t got;
		out_item_t want;
		got = out_ch.data;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_outputs.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected output idx=%0d val=%0d", got.out_index, got.out_value);
			end else begin
				want = expected_outputs.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: exp idx=%0d val=%0d last=%b, got idx=%0d val=%0d last=%b",
							want.out_index, want.out_value, want.last,
							got.out_index, got.out_value, got.last);
				end
			end
		end
	end
endmodule

>>> tb/sparse_mlp_one_hidden_relu_core_tb.sv
// Testbench top for the sparse perceptron core: loads networks, runs them, gives a verdict.
// Depends on smlp_pkg, smlp_if, the core and sparse_mlp_one_hidden_relu_core_chk.
`timescale 1ns / 1ps
module sparse_mlp_one_hidden_relu_core_tb;
	import smlp_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	bit   hold_off;
	int   sent_runs;

	smlp_if #(.payload_t(in_item_t))  in_ch (clk);
	smlp_if #(.payload_t(out_item_t)) out_ch (clk);

	sparse_mlp_one_hidden_relu_core DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	sparse_mlp_one_hidden_relu_core_chk checker_i (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#200ms;
		$display("sparse_mlp_one_hidden_relu_core_tb NOT OK");
		$finish;
	end

	// Receiver stall pattern, plus one long hold-off while stimulus continues.
	initial begin
		out_ch.ready <= 0;
		forever begin
			@(posedge clk);
			if (hold_off) out_ch.ready <= 0;
			else out_ch.ready <= ($urandom_range(0, 3) != 0) || (sent_runs % 3 == 0);
		end
	end

	int gap_left;
	int burst_left;

	// Sends one item, honoring the burst and gap pattern.
	task automatic send_item(logic [2:0] op, logic [11:0] addr, logic signed [31:0] v,
			logic [5:0] src, logic [6:0] fan);
		in_item_t it;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
		end
		while (gap_left > 0) begin
			in_ch.valid <= 0;
			@(posedge clk);
			gap_left--;
		end
		it.op = op; it.addr = addr; it.value = v; it.src_index = src; it.fan_in = fan;
		in_ch.valid <= 1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		burst_left--;
		if (op == OP_RUN) sent_runs++;
	endtask

	// Lets the checker see the last transfer, then waits for all outputs.
	task automatic go_idle();
		in_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rnd_val(int mag);
		case (mag)
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom());
			default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
		endcase
	endfunction

	// Loads a full, well-formed network with small fan-ins, values of the given kind.
	task automatic load_network(int mag, int max_fan);
		int total;
		int f;
		total = 0;
		for (int i = 0; i < NumInputs; i++)
			send_item(OP_INPUT, 12'(i), rnd_val(mag), 6'($urandom()), 7'($urandom()));
		for (int h = 0; h < NumHidden; h++) begin
			f = $urandom_range(0, max_fan);
			send_item(OP_FANIN, 12'(h), rnd_val(mag), 6'($urandom()), 7'(f));
			for (int j = 0; j < f; j++)
				send_item(OP_HWEIGHT, 12'(total + j), rnd_val(mag), 6'($urandom()), 7'($urandom()));
			total += f;
		end
		for (int b = 0; b < NumBiases; b++)
			send_item(OP_BIAS, 12'(b), rnd_val(mag), 6'($urandom()), 7'($urandom()));
		for (int w = 0; w < OutWeights; w++)
			send_item(OP_OWEIGHT, 12'(w), rnd_val(mag), 6'($urandom()), 7'($urandom()));
	endtask

	initial begin
		int mode;
		arst_n = 0;
		hold_off = 0;
		sent_runs = 0;
		burst_left = 0;
		gap_left = 0;
		in_ch.valid <= 0;
		in_ch.data <= '0;
		repeat (8) @(posedge clk);
		arst_n = 1;
		@(posedge clk);

		// Small values first, then the positive extreme with bad ops and addresses, then the negative extreme.
		load_network(3, 3);
		send_item(OP_RUN, 12'hfff, 32'sh7fffffff, 6'h3f, 7'h7f);
		go_idle();
		load_network(0, 1);
		send_item(3'd6, 12'h000, 32'sh80000000, 6'h00, 7'h00);
		send_item(3'd7, 12'hfff, 32'sh7fffffff, 6'h3f, 7'h7f);
		send_item(OP_BIAS, 12'hfff, 32'sh0, 6'h3f, 7'h7f);
		send_item(OP_INPUT, 12'h040, 32'sh0, 6'h0, 7'h0);
		send_item(OP_FANIN, 12'h040, 32'sh0, 6'h0, 7'h40);
		send_item(OP_OWEIGHT, 12'h400, 32'sh0, 6'h0, 7'h0);
		send_item(OP_RUN, 12'h000, 32'sh0, 6'h0, 7'h0);
		go_idle();
		load_network(1, 2);
		send_item(OP_RUN, 12'h000, 32'sh0, 6'h0, 7'h0);

		// Long receiver hold-off while runs keep being offered.
		fork
			begin
				hold_off = 1;
				repeat (4000) @(posedge clk);
				hold_off = 0;
			end
			begin
				repeat (3) send_item(OP_RUN, 12'($urandom()), rnd_val(2), 6'($urandom()), 7'($urandom()));
			end
		join
		go_idle();

		// Random part: mostly rewrites of existing entries and runs, some noise.
		for (int n = 0; n < 230; n++) begin
			mode = $urandom_range(0, 9);
			case (mode)
				0: send_item(OP_RUN, 12'($urandom()), rnd_val(2), 6'($urandom()), 7'($urandom()));
				1: send_item(OP_INPUT, 12'($urandom_range(0, NumInputs - 1)), rnd_val($urandom_range(0, 3)),
					6'($urandom()), 7'($urandom()));
				2: send_item(OP_BIAS, 12'($urandom_range(0, NumBiases - 1)), rnd_val($urandom_range(0, 3)),
					6'($urandom()), 7'($urandom()));
				3, 4: send_item(OP_OWEIGHT, 12'($urandom_range(0, OutWeights - 1)),
					rnd_val($urandom_range(0, 3)), 6'($urandom()), 7'($urandom()));
				5: send_item(OP_HWEIGHT, 12'($urandom_range(0, 127)), rnd_val($urandom_range(0, 3)),
					6'($urandom()), 7'($urandom()));
				6: send_item(3'($urandom_range(6, 7)), 12'($urandom()), rnd_val(2),
					6'($urandom()), 7'($urandom()));
				7: send_item(OP_FANIN, 12'($urandom_range(NumHidden, 4095)), rnd_val(2),
					6'($urandom()), 7'($urandom()));
				default: send_item(OP_INPUT, 12'($urandom_range(NumInputs, 4095)), rnd_val(2),
					6'($urandom()), 7'($urandom()));
			endcase
		end
		send_item(OP_RUN, 12'h0, 32'sh0, 6'h0, 7'h0);
		go_idle();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("sparse_mlp_one_hidden_relu_core_tb OK");
		else
			$display("sparse_mlp_one_hidden_relu_core_tb NOT OK");
		$finish;
	end
endmodule

>>> filelist.f
sv/smlp_pkg.sv
sv/smlp_if.sv
sv/smlp_ram.sv
sv/smlp_mac.sv
sv/sparse_mlp_one_hidden_relu_core.sv
tb/sparse_mlp_one_hidden_relu_core_chk.sv
tb/sparse_mlp_one_hidden_relu_core_tb.sv
